// ===== src/sleep_timer_wakeup_table_core_macros.svh =====
// Assertion macros used by the sleep timer wake-up table back end (stwt_back).
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SLEEP_TIMER_WAKEUP_TABLE_CORE_MACROS_SVH
`define SLEEP_TIMER_WAKEUP_TABLE_CORE_MACROS_SVH

// condition must hold at every edge
`define STWT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante in one cycle implies cons in the next
`define STWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/stwt_pkg.sv =====
// Package for the sleep timer wake-up table: sizes, codes and payload types.
// Used by stwt_front, stwt_back and sleep_timer_wakeup_table_core.
package stwt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic       FUNC_SLEEP  = 1'b0;
	localparam logic       FUNC_TICK   = 1'b1;

	localparam logic [1:0] KIND_WOKEN  = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	localparam logic [1:0] MODE_RR     = 2'd1;
	localparam logic [1:0] MODE_PRIO   = 2'd2;

	typedef struct packed {
		logic        func;
		logic [7:0]  thread_id;
		logic [15:0] sleep_ticks;
		logic        cpu_idle;
		logic        other_pending;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] woken_id;
		logic       yield_request;
		logic       disable_timer;
		logic       last;
	} out_item_t;

	typedef enum logic {
		OP_SLEEP = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  thread_id;
		logic [15:0] sleep_ticks;
		logic        cpu_idle;
		logic        other_pending;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

// ===== src/sleep_timer_wakeup_table_core.sv =====
// Sleep timer wake-up table, top level: joins the request front end and the
// table back end. Depends on stwt_pkg, stwt_front and stwt_back.
//
// Keeps up to ENTRIES sleeping thread ids, each with a saturating absolute wake
// time. A sleep request gives one transfer (accepted or full). A tick advances
// the 32-bit counter and then walks the table one entry per cycle, oldest
// first, unless a due entry waits for the output register, sending one
// transfer per woken thread and compacting the rest; it ends with one status
// transfer marked last. A two-deep command queue lets requests be taken while
// the back end works, and an output register lets the back end go on while a
// result waits. Configuration writes are always accepted and apply from the
// next cycle; the table needs no clearing pass.
module sleep_timer_wakeup_table_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  stwt_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output stwt_pkg::out_item_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);
	import stwt_pkg::*;

	q_head_t head;
	logic    pop;

	stwt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	stwt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== src/stwt_front.sv =====
// Front end of the sleep timer wake-up table: accepts requests, decodes them
// into commands and holds them in a short queue. Depends on stwt_pkg.
module stwt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  stwt_pkg::in_item_t req,
	output stwt_pkg::q_head_t head,
	input  logic              pop
);
	import stwt_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	cmd_t              cmd_in;
	logic              push;
	logic              do_pop;

	always_comb begin
		cmd_in.op            = (req.func == FUNC_TICK) ? OP_TICK : OP_SLEEP;
		cmd_in.thread_id     = req.thread_id;
		cmd_in.sleep_ticks   = req.sleep_ticks;
		cmd_in.cpu_idle      = req.cpu_idle;
		cmd_in.other_pending = req.other_pending;
	end

	assign req_ready  = (fill_q != QCNT_W'(QDEPTH));
	assign push       = req_valid && req_ready;
	assign do_pop     = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== src/stwt_back.sv =====
// Back end of the sleep timer wake-up table: tick counter, age-ordered entry
// table, scan sequencer and output register. Depends on stwt_pkg and macros.
`include "sleep_timer_wakeup_table_core_macros.svh"

module stwt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  stwt_pkg::q_head_t   head,
	output logic                pop,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output stwt_pkg::out_item_t rsp
);
	import stwt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_STAT = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [1:0]       mode_q;
	logic [31:0]      tick_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] w_q;
	logic             woken_q;
	logic             idle_q;
	logic             pend_q;

	// entries kept oldest first at positions 0 .. count_q-1
	logic [7:0]       ent_id_q   [ENTRIES];
	logic [31:0]      ent_wake_q [ENTRIES];

	logic             out_valid_q;
	out_item_t        out_q;

	logic             can_emit;
	logic             emit;
	out_item_t        out_d;
	logic             ent_we;
	logic [IDX_W-1:0] ent_widx;
	logic [7:0]       ent_wid;
	logic [31:0]      ent_wwake;
	logic [7:0]       rd_id;
	logic [31:0]      rd_wake;
	logic             due;
	logic             full;
	logic [32:0]      wake_sum;
	logic [31:0]      wake_sat;
	logic             quiet;

	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign can_emit  = !out_valid_q || rsp_ready;

	assign rd_id    = ent_id_q[r_q[IDX_W-1:0]];
	assign rd_wake  = ent_wake_q[r_q[IDX_W-1:0]];
	assign due      = (tick_q >= rd_wake);
	assign full     = (count_q == CNT_W'(ENTRIES));
	assign wake_sum = {1'b0, tick_q} + {17'd0, head.cmd.sleep_ticks};
	assign wake_sat = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
	assign quiet    = idle_q && !woken_q && (w_q == '0);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		out_d     = '0;
		ent_we    = 1'b0;
		ent_widx  = '0;
		ent_wid   = rd_id;
		ent_wwake = rd_wake;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (head.cmd.op == OP_TICK) begin
						pop     = 1'b1;
						state_d = ST_SCAN;
					end else if (can_emit) begin
						pop        = 1'b1;
						emit       = 1'b1;
						out_d.last = 1'b1;
						if (full) begin
							out_d.kind = KIND_FULL;
						end else begin
							out_d.kind = KIND_ACCEPT;
							ent_we     = 1'b1;
							ent_widx   = count_q[IDX_W-1:0];
							ent_wid    = head.cmd.thread_id;
							ent_wwake  = wake_sat;
						end
					end
				end
			end
			ST_SCAN: begin
				if (r_q == count_q) begin
					state_d = ST_STAT;
				end else if (!due) begin
					ent_we   = 1'b1;
					ent_widx = w_q[IDX_W-1:0];
				end else if (can_emit) begin
					emit           = 1'b1;
					out_d.kind     = KIND_WOKEN;
					out_d.woken_id = rd_id;
				end
			end
			ST_STAT: begin
				if (can_emit) begin
					emit                = 1'b1;
					out_d.kind          = KIND_STATUS;
					out_d.last          = 1'b1;
					out_d.disable_timer = quiet && !pend_q;
					out_d.yield_request = !quiet && (mode_q == MODE_RR || mode_q == MODE_PRIO);
					state_d             = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_id_q[ent_widx]   <= ent_wid;
			ent_wake_q[ent_widx] <= ent_wwake;
		end
		if (emit) begin
			out_q <= out_d;
		end
		if (state_q == ST_IDLE && pop && head.cmd.op == OP_TICK) begin
			idle_q <= head.cmd.cpu_idle;
			pend_q <= head.cmd.other_pending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= '0;
			tick_q      <= '0;
			count_q     <= '0;
			r_q         <= '0;
			w_q         <= '0;
			woken_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.cmd.op == OP_TICK) begin
						tick_q  <= (tick_q == 32'hFFFF_FFFF) ? tick_q : tick_q + 32'd1;
						r_q     <= '0;
						w_q     <= '0;
						woken_q <= 1'b0;
					end else if (pop && !full) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (r_q != count_q) begin
						if (!due) begin
							r_q <= r_q + 1'b1;
							w_q <= w_q + 1'b1;
						end else if (can_emit) begin
							r_q     <= r_q + 1'b1;
							woken_q <= 1'b1;
						end
					end
				end
				ST_STAT: begin
					if (can_emit) begin
						count_q <= w_q;
					end
				end
				default: count_q <= count_q;
			endcase
		end
	end

	`STWT_ASSERT(a_count_range, count_q <= CNT_W'(ENTRIES), "entry count beyond table size")
	`STWT_ASSERT(a_scan_ptrs, (state_q != ST_SCAN) || (w_q <= r_q && r_q <= count_q), "scan pointers out of order")
	`STWT_ASSERT_NEXT(a_status_last, state_q == ST_STAT && can_emit, out_valid_q && out_q.last && out_q.kind == KIND_STATUS && state_q == ST_IDLE, "status transfer not issued")
	`STWT_ASSERT_NEXT(a_woken_due, state_q == ST_SCAN && r_q != count_q && due && can_emit, out_valid_q && out_q.kind == KIND_WOKEN && !out_q.last, "due entry not reported")

endmodule
